// ----- src/dht_pkg.sv -----
// types and constants shared by the double hash table core
// no dependencies
package dht_pkg;

    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_STEP,
        S_RD0,
        S_PROBE,
        S_DONE
    } state_t;

    // phases of the constant remainder unit
    typedef enum logic [1:0] {
        R_IDLE,
        R_MUL,
        R_FOLD
    } rem_phase_t;

endpackage

// ----- src/dht_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module dht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 13
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/dht_rem.sv -----
// remainder by a constant divisor through a reciprocal multiply, a multiply phase then a fold phase per start
// depends on dht_pkg
module dht_rem
    import dht_pkg::*;
#(
    parameter int DIV = 13
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [KEY_W-1:0]       value,
    output logic                   busy,
    output logic [$clog2(DIV)-1:0] rem
);

    localparam int RW = $clog2(DIV);
    localparam int SH = KEY_W + RW;
    localparam int PW = 2 * KEY_W + 1;
    localparam int QW = KEY_W + 1 - RW;
    // reciprocal rounded up, gives the exact quotient for every key-wide value
    localparam logic [KEY_W:0] RECIP =
        (KEY_W+1)'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));
    localparam logic [RW-1:0] DIV_LO = RW'(DIV);

    rem_phase_t       phase_reg, phase_next;
    logic [KEY_W-1:0] val_reg, val_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [RW-1:0]    r_reg, r_next;
    logic [PW-1:0]    prod;

    // value times reciprocal, quotient sits in the upper bits
    assign prod = {{(KEY_W+1){1'b0}}, val_reg} * {{KEY_W{1'b0}}, RECIP};

    always_comb
    begin
        phase_next = phase_reg;
        val_next   = val_reg;
        quo_next   = quo_reg;
        r_next     = r_reg;
        case (phase_reg)
            R_MUL:
            begin
                quo_next   = prod[PW-1:SH];
                phase_next = R_FOLD;
            end
            R_FOLD:
            begin
                // remainder is below the divisor, so the low bits are enough
                r_next     = val_reg[RW-1:0] - quo_reg[RW-1:0] * DIV_LO;
                phase_next = R_IDLE;
            end
            default:
            begin
                phase_next = R_IDLE;
            end
        endcase
        if (start)
        begin
            val_next   = value;
            phase_next = R_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= R_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        quo_reg <= quo_next;
        r_reg   <= r_next;
    end

    assign busy = (phase_reg != R_IDLE);
    assign rem  = r_reg;

endmodule

// ----- src/double_hash_table_insert_search_core.sv -----
// double hashing open addressing table, insert and search
// steps: a refused insert on a full table goes straight to the output load; otherwise the
//   key hash, the step reduction, the home slot read, k probes (1 to TABLE_SIZE, one ram
//   read and compare each) and the output load
// flow: one word at a time, s_tready returns in the same cycle the result is registered;
//   a held result word stalls the input
// reset: clearing pass over every ram slot, no word accepted meanwhile
module double_hash_table_insert_search_core
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = 13,
    parameter int STEP_PRIME = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] key, [31] zero
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] slot, [7:4] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int OW  = $clog2(TABLE_SIZE + 1);
    localparam int SPW = $clog2(STEP_PRIME + 1);
    localparam int EW  = KEY_W + 1;
    localparam logic [IW:0]  TS_V   = (IW+1)'(TABLE_SIZE);
    localparam logic [OW-1:0] TS_CNT = OW'(TABLE_SIZE);
    localparam logic [SPW-1:0] SP_V = SPW'(STEP_PRIME);

    state_t           state_reg, state_next;
    logic [OW-1:0]    occ_reg, occ_next;
    logic [IW-1:0]    clr_reg, clr_next;
    logic [IW-1:0]    pos_reg, pos_next;
    logic [IW-1:0]    chk_reg, chk_next;
    logic [IW-1:0]    step_reg, step_next;
    logic [OW-1:0]    probe_reg, probe_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             func_reg, func_next;
    status_t          res_status_reg, res_status_next;
    logic [IW-1:0]    res_slot_reg, res_slot_next;
    logic             mv_reg, mv_next;
    status_t          m_status_reg, m_status_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;

    logic             ts_start, sp_start;
    logic [KEY_W-1:0] ts_val;
    logic             ts_busy, sp_busy;
    logic [IW-1:0]    ts_rem;
    logic [$clog2(STEP_PRIME)-1:0] sp_rem;
    logic [SPW-1:0]   raw_step;

    logic             we;
    logic [IW-1:0]    waddr;
    logic [EW-1:0]    wdata, rdata;

    logic [IW:0]      adv_sum;
    logic [IW-1:0]    adv_pos;
    logic             last_probe;
    logic [IW+SLOT_W-1:0] slot_ext;

    dht_rem #(.DIV(TABLE_SIZE)) u_rem_ts (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ts_start),
        .value (ts_val),
        .busy  (ts_busy),
        .rem   (ts_rem)
    );

    dht_rem #(.DIV(STEP_PRIME)) u_rem_sp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sp_start),
        .value (s_tdata[KEY_W-1:0]),
        .busy  (sp_busy),
        .rem   (sp_rem)
    );

    dht_ram #(.WIDTH(EW), .DEPTH(TABLE_SIZE)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (pos_reg),
        .rdata (rdata)
    );

    // probe walk: pos + step, folded back into the table
    assign adv_sum = {1'b0, pos_reg} + {1'b0, step_reg};
    assign adv_pos = (adv_sum >= TS_V) ? IW'(adv_sum - TS_V) : adv_sum[IW-1:0];
    assign raw_step = SP_V - SPW'(sp_rem);
    assign last_probe = (probe_reg + 1'b1) == TS_CNT;
    assign slot_ext = {{SLOT_W{1'b0}}, res_slot_reg};

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        clr_next        = clr_reg;
        pos_next        = pos_reg;
        chk_next        = chk_reg;
        step_next       = step_reg;
        probe_next      = probe_reg;
        key_next        = key_reg;
        func_next       = func_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        mv_next         = mv_reg;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        ts_start        = 1'b0;
        sp_start        = 1'b0;
        ts_val          = s_tdata[KEY_W-1:0];
        we              = 1'b0;
        waddr           = chk_reg;
        wdata           = {1'b1, key_reg};

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next  = s_tdata[KEY_W-1:0];
                    func_next = s_tuser[0];
                    if (s_tuser[0] == FUNC_INSERT && occ_reg >= TS_CNT)
                    begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ts_start   = 1'b1;
                        sp_start   = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (!ts_busy && !sp_busy)
                begin
                    pos_next   = ts_rem;
                    // reduce the raw step modulo the table size
                    ts_val     = {{(KEY_W-SPW){1'b0}}, raw_step};
                    ts_start   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (!ts_busy)
                begin
                    step_next  = ts_rem;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                chk_next   = pos_reg;
                pos_next   = adv_pos;
                probe_next = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                chk_next   = pos_reg;
                pos_next   = adv_pos;
                probe_next = probe_reg + 1'b1;
                if (func_reg == FUNC_INSERT)
                begin
                    if (!rdata[KEY_W])
                    begin
                        we              = 1'b1;
                        occ_next        = occ_reg + 1'b1;
                        res_status_next = ST_INSERTED;
                        res_slot_next   = chk_reg;
                        state_next      = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    if (!rdata[KEY_W])
                    begin
                        res_status_next = ST_MISSING;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                    else if (rdata[KEY_W-1:0] == key_reg)
                    begin
                        res_status_next = ST_FOUND;
                        res_slot_next   = chk_reg;
                        state_next      = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = ST_MISSING;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next       = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = slot_ext[SLOT_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            occ_reg   <= '0;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        chk_reg        <= chk_next;
        step_reg       <= step_next;
        probe_reg      <= probe_next;
        key_reg        <= key_next;
        func_reg       <= func_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(8-SLOT_W){1'b0}}, m_slot_reg};

    // occupancy can never pass the table size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= TS_CNT)
        else $error("occupancy above table size");

    // a successful insert adds exactly one key
    a_occ_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE && we) |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("occupancy not incremented on insert");

    // refused and missing results report slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_MISSING)) |-> m_tdata == 8'd0)
        else $error("nonzero slot on refused or missing result");

endmodule

// ----- tb/double_hash_table_insert_search_core_tb.sv -----
// self-checking bench for the double hashing insert/search core
// depends on dht_pkg and double_hash_table_insert_search_core
// a clocked driver and monitor check each result word against an in-bench table model
module double_hash_table_insert_search_core_tb;
    import dht_pkg::*;

    localparam int TBL          = 13;
    localparam int STRIDE_PRIME = 11;
    localparam int TAIL_WORDS   = 60;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
    } key_request_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } probe_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    key_request_t  key_requests[$];
    probe_result_t probe_results_due[$];
    logic [KEY_W-1:0] stored_keys[$];

    // model of the table contents
    logic [KEY_W-1:0] slot_key[TBL];
    bit               slot_used[TBL];
    int               used_count = 0;

    int total_words = 0;
    int n_sent      = 0;
    int mismatches  = 0;
    int seen_inserted = 0;
    int seen_full     = 0;
    int seen_found    = 0;
    int seen_missing  = 0;

    int  send_gap  = 0;
    int  recv_gap  = 0;
    logic hold     = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;

    double_hash_table_insert_search_core #(
        .TABLE_SIZE (TBL),
        .STEP_PRIME (STRIDE_PRIME)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // walks the probe sequence of one key and updates the model table on insert
    function automatic probe_result_t hash_probe(input logic func, input logic [KEY_W-1:0] key);
        probe_result_t r;
        int unsigned   kv;
        int unsigned   pos;
        int unsigned   stride;
        bit            done;
        kv     = {1'b0, key};
        pos    = kv % TBL;
        stride = (STRIDE_PRIME - (kv % STRIDE_PRIME)) % TBL;
        r.status = (func == FUNC_INSERT) ? ST_FULL : ST_MISSING;
        r.slot   = '0;
        done     = (func == FUNC_INSERT) && (used_count >= TBL);
        for (int i = 0; i < TBL && !done; i++) begin
            if (func == FUNC_INSERT) begin
                if (!slot_used[pos]) begin
                    slot_used[pos] = 1'b1;
                    slot_key[pos]  = key;
                    used_count++;
                    r.status = ST_INSERTED;
                    r.slot   = pos[SLOT_W-1:0];
                    done     = 1'b1;
                end
            end else if (!slot_used[pos]) begin
                done = 1'b1;
            end else if (slot_key[pos] == key) begin
                r.status = ST_FOUND;
                r.slot   = pos[SLOT_W-1:0];
                done     = 1'b1;
            end
            if (!done)
                pos = (pos + stride) % TBL;
        end
        return r;
    endfunction

    function automatic void queue_word(input logic func, input logic [KEY_W-1:0] key);
        key_request_t w;
        w.func = func;
        w.key  = key;
        key_requests.push_back(w);
        if (func == FUNC_INSERT)
            stored_keys.push_back(key);
        total_words++;
    endfunction

    function automatic bit bursts_allowed();
        return (total_words - n_sent) > TAIL_WORDS;
    endfunction

    // sender: one word held until taken, random bubbles between words
    always @(posedge clk or negedge rst_n) begin : drive_words
        key_request_t w;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                probe_results_due.push_back(hash_probe(s_tuser[0], s_tdata[KEY_W-1:0]));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (key_requests.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (bursts_allowed() && $urandom_range(0, 3) == 0) begin
                    send_gap <= $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end else begin
                    w = key_requests.pop_front();
                    s_tdata  <= {1'b0, w.key};
                    s_tuser  <= w.func;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // one long receiver hold-off while the sender keeps offering
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold      <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end else if (!hold_done && n_sent >= 120) begin
            hold      <= 1'b1;
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
        end else if (hold) begin
            if (hold_cnt == 1)
                hold <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
    end

    // receiver: checks each result word against the oldest prediction
    always @(posedge clk or negedge rst_n) begin : check_words
        probe_result_t due;
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (probe_results_due.size() == 0) begin
                    $error("result word with nothing outstanding: status %0d slot %0d",
                           m_tuser, m_tdata[SLOT_W-1:0]);
                    mismatches++;
                end else begin
                    due = probe_results_due.pop_front();
                    if (m_tuser !== due.status) begin
                        $error("status: expected %0d, actual %0d", due.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[SLOT_W-1:0] !== due.slot) begin
                        $error("slot: expected %0d, actual %0d", due.slot,
                               m_tdata[SLOT_W-1:0]);
                        mismatches++;
                    end
                    case (due.status)
                        ST_INSERTED: seen_inserted++;
                        ST_FULL:     seen_full++;
                        ST_FOUND:    seen_found++;
                        default:     seen_missing++;
                    endcase
                end
            end
            if (hold) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (bursts_allowed() && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int               r;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < TBL; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
        end

        // extremes, an empty home slot, a duplicate and a collision chain
        queue_word(FUNC_INSERT, '0);
        queue_word(FUNC_INSERT, {KEY_W{1'b1}});
        queue_word(FUNC_SEARCH, '0);
        queue_word(FUNC_SEARCH, {KEY_W{1'b1}});
        queue_word(FUNC_SEARCH, 31'd5);
        queue_word(FUNC_INSERT, '0);
        queue_word(FUNC_INSERT, 31'd13);
        queue_word(FUNC_INSERT, 31'd26);
        queue_word(FUNC_SEARCH, 31'd26);
        queue_word(FUNC_SEARCH, 31'd39);
        // fill the rest with keys sharing home slot zero
        for (int i = 0; i < 8; i++)
            queue_word(FUNC_INSERT, KEY_W'(13 * $urandom_range(3, 165191049)));
        // full table: refused insert, a miss that visits every slot, a deep hit
        queue_word(FUNC_INSERT, KEY_W'($urandom()));
        queue_word(FUNC_SEARCH, 31'd39);
        queue_word(FUNC_SEARCH, stored_keys[stored_keys.size() - 1]);

        for (int i = 0; i < 400; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                queue_word(FUNC_INSERT, KEY_W'($urandom()));
            end else if (r < 55) begin
                queue_word(FUNC_SEARCH,
                           stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            end else if (r < 75) begin
                // same home slot as a stored key, usually absent
                k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                queue_word(FUNC_SEARCH, KEY_W'(k + 13 * $urandom_range(1, 50)));
            end else begin
                queue_word(FUNC_SEARCH, KEY_W'($urandom()));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < total_words)
            @(posedge clk);
        while (probe_results_due.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("ran %0d words through the table, including a full table and a long hold-off",
                 total_words);
        $display("outcomes: %0d inserted, %0d refused, %0d found, %0d not found",
                 seen_inserted, seen_full, seen_found, seen_missing);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
